>>> hdl/crtc_pkg.sv
package crtc_pkg;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    localparam logic [7:0] SEL_FIRST = 8'h08;
    localparam logic [7:0] SEL_LAST  = 8'h0C;

    localparam logic [2:0] REG_SECONDS = 3'd0;
    localparam logic [2:0] REG_MINUTES = 3'd1;
    localparam logic [2:0] REG_HOURS   = 3'd2;
    localparam logic [2:0] REG_DAYLOW  = 3'd3;
    localparam logic [2:0] REG_CONTROL = 3'd4;

    localparam logic [7:0] LATCH_CLEAR = 8'h00;
    localparam logic [7:0] LATCH_SET   = 8'h01;

    localparam int CTRL_DAY_HI_BIT = 0;
    localparam int CTRL_HALT_BIT   = 6;
    localparam int CTRL_CARRY_BIT  = 7;

    localparam logic [5:0] SECONDS_MAX = 6'd59;
    localparam logic [5:0] MINUTES_MAX = 6'd59;
    localparam logic [4:0] HOURS_MAX   = 5'd23;
    localparam logic [8:0] DAYS_MAX    = 9'h1FF;

    localparam logic [2:0] OP_NOP    = 3'd0;
    localparam logic [2:0] OP_TICK   = 3'd1;
    localparam logic [2:0] OP_READ   = 3'd2;
    localparam logic [2:0] OP_WRITE  = 3'd3;
    localparam logic [2:0] OP_ARM    = 3'd4;
    localparam logic [2:0] OP_DISARM = 3'd5;

    typedef struct packed {
        logic [2:0] op;
        logic [2:0] reg_idx;
        logic [7:0] data;
    } crtc_op_t;

endpackage

>>> hdl/crtc_if.sv
interface crtc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] reg_select;
    logic [7:0] write_data;

    modport source (output valid, output command, output reg_select, output write_data,
                    input ready);
    modport sink   (input valid, input command, input reg_select, input write_data,
                    output ready);
endinterface

interface crtc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       latch_armed;

    modport source (output valid, output read_data, output latch_armed, input ready);
    modport sink   (input valid, input read_data, input latch_armed, output ready);
endinterface

>>> hdl/crtc_front.sv
module crtc_front
    import crtc_pkg::*;
(
    crtc_in_if.sink  bus,
    input  logic     q_full,
    output logic     q_push,
    output crtc_op_t q_op
);

    logic in_range;

    assign in_range  = (bus.reg_select >= SEL_FIRST) && (bus.reg_select <= SEL_LAST);
    assign bus.ready = !q_full;
    assign q_push    = bus.valid && !q_full;

    always_comb
    begin
        q_op.reg_idx = 3'(bus.reg_select - SEL_FIRST);
        q_op.data    = bus.write_data;
        q_op.op      = OP_NOP;
        case (bus.command)
            CMD_TICK:
            begin
                q_op.op = OP_TICK;
            end
            CMD_READ:
            begin
                if (in_range)
                begin
                    q_op.op = OP_READ;
                end
            end
            CMD_WRITE:
            begin
                if (in_range)
                begin
                    q_op.op = OP_WRITE;
                end
                else if (bus.write_data == LATCH_CLEAR)
                begin
                    q_op.op = OP_DISARM;
                end
                else if (bus.write_data == LATCH_SET)
                begin
                    q_op.op = OP_ARM;
                end
            end
            default:
            begin
                q_op.op = OP_NOP;
            end
        endcase
    end

endmodule

>>> hdl/crtc_queue.sv
module crtc_queue
    import crtc_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  crtc_op_t push_op,
    output logic     full,
    input  logic     pop,
    output logic     empty,
    output crtc_op_t head_op
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    crtc_op_t      slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign head_op = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

>>> hdl/crtc_back.sv
module crtc_back
    import crtc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     empty,
    input  crtc_op_t head_op,
    output logic     pop,
    crtc_out_if.source rsp
);

    logic [5:0] run_sec_reg,   run_sec_next;
    logic [5:0] run_min_reg,   run_min_next;
    logic [4:0] run_hour_reg,  run_hour_next;
    logic [8:0] run_day_reg,   run_day_next;
    logic       run_carry_reg, run_carry_next;
    logic [7:0] shown_sec_reg,  shown_sec_next;
    logic [7:0] shown_min_reg,  shown_min_next;
    logic [7:0] shown_hour_reg, shown_hour_next;
    logic [8:0] shown_day_reg,  shown_day_next;
    logic       shown_carry_reg, shown_carry_next;
    logic       halt_reg,  halt_next;
    logic       armed_reg, armed_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_data_reg,  out_data_next;
    logic [7:0] rd_value;

    assign pop           = !empty && (!out_valid_reg || rsp.ready);
    assign rsp.valid     = out_valid_reg;
    assign rsp.read_data = out_data_reg;
    assign rsp.latch_armed = armed_reg;

    always_comb
    begin
        rd_value = '0;
        case (head_op.reg_idx)
            REG_SECONDS: rd_value = shown_sec_reg;
            REG_MINUTES: rd_value = shown_min_reg;
            REG_HOURS:   rd_value = shown_hour_reg;
            REG_DAYLOW:  rd_value = shown_day_reg[7:0];
            REG_CONTROL:
            begin
                rd_value[CTRL_DAY_HI_BIT] = shown_day_reg[8];
                rd_value[CTRL_HALT_BIT]   = halt_reg;
                rd_value[CTRL_CARRY_BIT]  = shown_carry_reg;
            end
            default:     rd_value = '0;
        endcase
    end

    always_comb
    begin
        run_sec_next     = run_sec_reg;
        run_min_next     = run_min_reg;
        run_hour_next    = run_hour_reg;
        run_day_next     = run_day_reg;
        run_carry_next   = run_carry_reg;
        shown_sec_next   = shown_sec_reg;
        shown_min_next   = shown_min_reg;
        shown_hour_next  = shown_hour_reg;
        shown_day_next   = shown_day_reg;
        shown_carry_next = shown_carry_reg;
        halt_next        = halt_reg;
        armed_next       = armed_reg;
        out_data_next    = out_data_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        if (pop)
        begin
            out_valid_next = 1'b1;
            out_data_next  = '0;
            case (head_op.op)
                OP_TICK:
                begin
                    if (run_sec_reg != SECONDS_MAX)
                    begin
                        run_sec_next = run_sec_reg + 1'b1;
                    end
                    else
                    begin
                        run_sec_next = '0;
                        if (run_min_reg != MINUTES_MAX)
                        begin
                            run_min_next = run_min_reg + 1'b1;
                        end
                        else
                        begin
                            run_min_next = '0;
                            if (run_hour_reg != HOURS_MAX)
                            begin
                                run_hour_next = run_hour_reg + 1'b1;
                            end
                            else
                            begin
                                run_hour_next = '0;
                                run_day_next  = run_day_reg + 1'b1;
                                if (run_day_reg == DAYS_MAX)
                                begin
                                    run_carry_next = 1'b1;
                                end
                            end
                        end
                    end
                end
                OP_READ:
                begin
                    out_data_next = rd_value;
                end
                OP_WRITE:
                begin
                    case (head_op.reg_idx)
                        REG_SECONDS: shown_sec_next  = head_op.data;
                        REG_MINUTES: shown_min_next  = head_op.data;
                        REG_HOURS:   shown_hour_next = head_op.data;
                        REG_DAYLOW:  shown_day_next  = {shown_day_reg[8], head_op.data};
                        REG_CONTROL:
                        begin
                            shown_day_next   = {head_op.data[CTRL_DAY_HI_BIT],
                                                shown_day_reg[7:0]};
                            halt_next        = head_op.data[CTRL_HALT_BIT];
                            shown_carry_next = head_op.data[CTRL_CARRY_BIT];
                        end
                        default:
                        begin
                            halt_next = halt_reg;
                        end
                    endcase
                end
                OP_ARM:
                begin
                    if (!armed_reg)
                    begin
                        armed_next       = 1'b1;
                        shown_sec_next   = {2'b00, run_sec_reg};
                        shown_min_next   = {2'b00, run_min_reg};
                        shown_hour_next  = {3'b000, run_hour_reg};
                        shown_day_next   = run_day_reg;
                        shown_carry_next = run_carry_reg;
                    end
                end
                OP_DISARM:
                begin
                    armed_next = 1'b0;
                end
                default:
                begin
                    out_data_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_sec_reg     <= '0;
            run_min_reg     <= '0;
            run_hour_reg    <= '0;
            run_day_reg     <= '0;
            run_carry_reg   <= 1'b0;
            shown_sec_reg   <= '0;
            shown_min_reg   <= '0;
            shown_hour_reg  <= '0;
            shown_day_reg   <= '0;
            shown_carry_reg <= 1'b0;
            halt_reg        <= 1'b0;
            armed_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            run_sec_reg     <= run_sec_next;
            run_min_reg     <= run_min_next;
            run_hour_reg    <= run_hour_next;
            run_day_reg     <= run_day_next;
            run_carry_reg   <= run_carry_next;
            shown_sec_reg   <= shown_sec_next;
            shown_min_reg   <= shown_min_next;
            shown_hour_reg  <= shown_hour_next;
            shown_day_reg   <= shown_day_next;
            shown_carry_reg <= shown_carry_next;
            halt_reg        <= halt_next;
            armed_reg       <= armed_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (run_sec_reg <= SECONDS_MAX) && (run_min_reg <= MINUTES_MAX)
        && (run_hour_reg <= HOURS_MAX))
        else $error("running clock field out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        run_carry_reg |=> run_carry_reg)
        else $error("running carry cleared");

    assert property (@(posedge clk) disable iff (!rst_n)
        (run_sec_reg != $past(run_sec_reg)) |-> $past(pop && head_op.op == OP_TICK))
        else $error("running seconds moved without a tick");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(armed_reg) |-> $past(pop && head_op.op == OP_ARM))
        else $error("latch armed without an arm request");

endmodule

>>> hdl/cartridge_real_time_clock_top.sv
// Cartridge real-time clock with MBC3-style registers. Each request is a one-second
// tick, a register read or a register write, and each yields exactly one response
// carrying read_data (zero except on reads of selects 8..12) and the latch state.
// A request is taken every cycle while the queue is not full: the decoder feeds a
// small queue and the execute stage updates the clock and registers the response at
// the edge that pops the request. With the queue empty and the response side not
// stalling, that is the edge after acceptance. Back-pressure on the response side
// fills the response register and then the queue, QUEUE_DEPTH requests deep, before
// the request side stalls.
module cartridge_real_time_clock_top
    import crtc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    crtc_in_if.sink    bus,
    crtc_out_if.source rsp
);

    logic     q_full;
    logic     q_empty;
    logic     q_push;
    logic     q_pop;
    crtc_op_t q_in_op;
    crtc_op_t q_head_op;

    crtc_front u_front (
        .bus    (bus),
        .q_full (q_full),
        .q_push (q_push),
        .q_op   (q_in_op)
    );

    crtc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_op (q_in_op),
        .full    (q_full),
        .pop     (q_pop),
        .empty   (q_empty),
        .head_op (q_head_op)
    );

    crtc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .empty   (q_empty),
        .head_op (q_head_op),
        .pop     (q_pop),
        .rsp     (rsp)
    );

endmodule
